[sv/pd_steering_filtered_derivative_core_defines.svh]
// Assertion macros shared by the steering controller modules.
`ifndef PD_STEERING_FILTERED_DERIVATIVE_CORE_DEFINES_SVH
`define PD_STEERING_FILTERED_DERIVATIVE_CORE_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during rst.
`define PDSFD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off during rst.
`define PDSFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/pdsfd_pkg.sv]
// Shared types, constants and microcode for the PD steering controller.
package pdsfd_pkg;

  localparam int FRAC    = 16;
  localparam int GAIN_W  = 8;
  localparam int POS_W   = 8;
  localparam int WIDE_W  = 16;
  localparam int CMD_W   = 16;
  localparam int ERR_W   = 9;
  localparam int PERR_W  = 10;
  localparam int DER_W   = 11;
  localparam int SM_W    = 26;
  localparam int MA_W    = 26;
  localparam int MB_W    = 17;
  localparam int PROD_W  = MA_W + MB_W;
  localparam int ACC_W   = 44;
  localparam int IDX_W   = 3;

  localparam int COEF_OLD = 62259;  // 0.95 in Q0.16
  localparam int COEF_NEW = 3277;   // 0.05 in Q0.16

  localparam logic [POS_W-1:0]  CAMERA_CENTER_RST = 8'd64;
  localparam logic [GAIN_W-1:0] PROP_GAIN_RST     = 8'd5;
  localparam logic [GAIN_W-1:0] DERIV_GAIN_RST    = 8'd70;
  localparam logic [WIDE_W-1:0] DERIV_LIMIT_RST   = 16'd1300;
  localparam logic [WIDE_W-1:0] SERVO_CENTER_RST  = 16'd32768;
  localparam logic [WIDE_W-1:0] SERVO_MIN_RST     = 16'd0;
  localparam logic [WIDE_W-1:0] SERVO_MAX_RST     = 16'd65535;

  typedef enum logic [IDX_W-1:0] {
    REG_CAMERA_CENTER = 3'd0,
    REG_PROP_GAIN     = 3'd1,
    REG_DERIV_GAIN    = 3'd2,
    REG_DERIV_LIMIT   = 3'd3,
    REG_SERVO_CENTER  = 3'd4,
    REG_SERVO_MIN     = 3'd5,
    REG_SERVO_MAX     = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [POS_W-1:0]  camera_center;
    logic [GAIN_W-1:0] prop_gain;
    logic [GAIN_W-1:0] deriv_gain;
    logic [WIDE_W-1:0] deriv_limit;
    logic [WIDE_W-1:0] servo_center;
    logic [WIDE_W-1:0] servo_min;
    logic [WIDE_W-1:0] servo_max;
  } cfg_t;

  // Microprogram
  localparam int NSTEPS = 9;
  localparam int PC_W   = $clog2(NSTEPS);
  localparam logic [PC_W-1:0] PC_LAST = PC_W'(NSTEPS - 1);

  typedef logic [PC_W-1:0] pc_t;

  typedef enum logic [1:0] {
    MUL_OLD,   // smoothed * 0.95
    MUL_NEW,   // derivative * 0.05
    MUL_DG,    // smoothed * deriv_gain
    MUL_PG     // error * prop_gain
  } mul_sel_t;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_ROUND,    // product plus half lsb
    ACC_ADD_SH,   // add product scaled up by Q.16
    ACC_CLAMP,    // clamped derivative term
    ACC_ADD_CMD   // add scaled product and servo centre
  } acc_op_t;

  typedef enum logic [1:0] {
    JC_NONE,
    JC_IN_WAIT,
    JC_OUT_BUSY
  } jcond_t;

  typedef struct packed {
    logic     take_in;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     load_sm;
    logic     load_out;
    jcond_t   cond;
    pc_t      target;
  } ctrl_t;

  typedef struct packed {
    logic in_wait;
    logic out_busy;
  } stat_t;

  function automatic ctrl_t ucode(input pc_t pc);
    ctrl_t w;
    w = '{take_in: 1'b0, mul_sel: MUL_OLD, acc_op: ACC_HOLD, load_sm: 1'b0,
          load_out: 1'b0, cond: JC_NONE, target: '0};
    unique case (pc)
      4'd0: begin
        w.take_in = 1'b1;
        w.cond    = JC_IN_WAIT;
        w.target  = 4'd0;
      end
      4'd1: w.mul_sel = MUL_OLD;
      4'd2: begin
        w.acc_op  = ACC_ROUND;
        w.mul_sel = MUL_NEW;
      end
      4'd3: w.acc_op = ACC_ADD_SH;
      4'd4: w.load_sm = 1'b1;
      4'd5: w.mul_sel = MUL_DG;
      4'd6: begin
        w.acc_op  = ACC_CLAMP;
        w.mul_sel = MUL_PG;
      end
      4'd7: w.acc_op = ACC_ADD_CMD;
      4'd8: begin
        w.load_out = 1'b1;
        w.cond     = JC_OUT_BUSY;
        w.target   = 4'd8;
      end
      default: begin
        w.cond   = JC_NONE;
      end
    endcase
    return w;
  endfunction

endpackage

[sv/pdsfd_seq.sv]
// Microcode sequencer: step counter, control store lookup and jumps.
`include "pd_steering_filtered_derivative_core_defines.svh"

module pdsfd_seq (
  input  logic              clk,
  input  logic              rst,
  input  pdsfd_pkg::stat_t  stat,
  output pdsfd_pkg::ctrl_t  ctrl
);

  pdsfd_pkg::pc_t   pc;
  pdsfd_pkg::pc_t   pc_next;
  pdsfd_pkg::ctrl_t word;
  logic             jump;

  assign word = pdsfd_pkg::ucode(pc);
  assign ctrl = word;

  always_comb begin
    unique case (word.cond)
      pdsfd_pkg::JC_IN_WAIT:  jump = stat.in_wait;
      pdsfd_pkg::JC_OUT_BUSY: jump = stat.out_busy;
      default:                jump = 1'b0;
    endcase
  end

  always_comb begin
    priority if (jump) begin
      pc_next = word.target;
    end else if (pc == pdsfd_pkg::PC_LAST) begin
      pc_next = '0;
    end else begin
      pc_next = pc + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0;
    end else begin
      pc <= pc_next;
    end
  end

  `PDSFD_ASSERT_NEXT(a_take_advances, word.take_in && !stat.in_wait, pc == 4'd1, "accepted word did not start the program")
  `PDSFD_ASSERT_NOW(a_pc_range, 1'b1, pc <= pdsfd_pkg::PC_LAST, "step counter out of program")
  `PDSFD_ASSERT_NEXT(a_wrap, pc == pdsfd_pkg::PC_LAST && !stat.out_busy, pc == 4'd0, "program did not return to wait step")

endmodule

[sv/pdsfd_datapath.sv]
// Datapath: shared multiplier, accumulator, filter state and output register.
`include "pd_steering_filtered_derivative_core_defines.svh"

module pdsfd_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  pdsfd_pkg::ctrl_t                ctrl,
  input  pdsfd_pkg::cfg_t                 cfg,
  input  logic                            in_valid,
  input  logic [pdsfd_pkg::POS_W-1:0]     line_center,
  input  logic                            out_stall,
  output logic                            out_valid,
  output logic [pdsfd_pkg::CMD_W-1:0]     servo_command,
  output pdsfd_pkg::stat_t                stat
);

  localparam int FRAC  = pdsfd_pkg::FRAC;
  localparam int ACC_W = pdsfd_pkg::ACC_W;
  localparam int HI_W  = ACC_W - FRAC;
  localparam int SM_W  = pdsfd_pkg::SM_W;

  logic signed [pdsfd_pkg::ERR_W-1:0]  err;
  logic signed [pdsfd_pkg::ERR_W-1:0]  err_new;
  logic signed [pdsfd_pkg::PERR_W-1:0] prev_err;
  logic signed [pdsfd_pkg::DER_W-1:0]  deriv;
  logic signed [SM_W-1:0]              sm;
  logic signed [pdsfd_pkg::MA_W-1:0]   mul_a;
  logic signed [pdsfd_pkg::MB_W-1:0]   mul_b;
  logic signed [pdsfd_pkg::PROD_W-1:0] mul_p;
  logic signed [pdsfd_pkg::PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]             acc;
  logic signed [ACC_W-1:0]             acc_next;
  logic signed [ACC_W-1:0]             prod_x;
  logic signed [ACC_W-1:0]             prod_sh;
  logic signed [ACC_W-1:0]             lim_x;
  logic signed [ACC_W-1:0]             sc_x;
  logic signed [ACC_W-1:0]             lo_x;
  logic signed [ACC_W-1:0]             hi_x;
  logic signed [HI_W-1:0]              acc_hi;
  logic        [HI_W-SM_W:0]           acc_top;
  logic signed [SM_W-1:0]              sm_sat;
  logic        [pdsfd_pkg::CMD_W-1:0]  cmd;
  logic                                take;
  logic                                put;

  assign stat.in_wait  = !in_valid;
  assign stat.out_busy = out_valid && out_stall;

  assign take = ctrl.take_in && in_valid;
  assign put  = ctrl.load_out && !stat.out_busy;

  assign err_new = $signed({1'b0, cfg.camera_center}) - $signed({1'b0, line_center});

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_err <= '0;
      sm       <= '0;
    end else begin
      if (take) begin
        prev_err <= pdsfd_pkg::PERR_W'(err_new);
      end
      if (ctrl.load_sm) begin
        sm <= sm_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      err   <= err_new;
      deriv <= pdsfd_pkg::DER_W'(err_new) - pdsfd_pkg::DER_W'(prev_err);
    end
  end

  // Shared multiplier
  always_comb begin
    unique case (ctrl.mul_sel)
      pdsfd_pkg::MUL_OLD: begin
        mul_a = sm;
        mul_b = $signed(pdsfd_pkg::MB_W'(pdsfd_pkg::COEF_OLD));
      end
      pdsfd_pkg::MUL_NEW: begin
        mul_a = pdsfd_pkg::MA_W'(deriv);
        mul_b = $signed(pdsfd_pkg::MB_W'(pdsfd_pkg::COEF_NEW));
      end
      pdsfd_pkg::MUL_DG: begin
        mul_a = sm;
        mul_b = $signed(pdsfd_pkg::MB_W'({1'b0, cfg.deriv_gain}));
      end
      pdsfd_pkg::MUL_PG: begin
        mul_a = pdsfd_pkg::MA_W'(err);
        mul_b = $signed(pdsfd_pkg::MB_W'({1'b0, cfg.prop_gain}));
      end
      default: begin
        mul_a = sm;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk) begin
    prod <= mul_p;
  end

  assign prod_x  = ACC_W'(prod);
  assign prod_sh = $signed({prod[HI_W-1:0], {FRAC{1'b0}}});
  assign lim_x   = $signed(ACC_W'({cfg.deriv_limit, {FRAC{1'b0}}}));
  assign sc_x    = $signed(ACC_W'({cfg.servo_center, {FRAC{1'b0}}}));
  assign lo_x    = $signed(ACC_W'({cfg.servo_min, {FRAC{1'b0}}}));
  assign hi_x    = $signed(ACC_W'({cfg.servo_max, {FRAC{1'b0}}}));

  always_comb begin
    unique case (ctrl.acc_op)
      pdsfd_pkg::ACC_ROUND:  acc_next = prod_x + $signed(ACC_W'(1 << (FRAC - 1)));
      pdsfd_pkg::ACC_ADD_SH: acc_next = acc + prod_sh;
      pdsfd_pkg::ACC_CLAMP: begin
        priority if (prod_x < -lim_x) begin
          acc_next = -lim_x;
        end else if (prod_x > lim_x) begin
          acc_next = lim_x;
        end else begin
          acc_next = prod_x;
        end
      end
      pdsfd_pkg::ACC_ADD_CMD: acc_next = acc + prod_sh + sc_x;
      default:                acc_next = acc;
    endcase
  end

  always_ff @(posedge clk) begin
    acc <= acc_next;
  end

  // floor(acc / 2^16), saturated to the filter state width
  assign acc_hi  = acc[ACC_W-1:FRAC];
  assign acc_top = acc_hi[HI_W-1:SM_W-1];

  always_comb begin
    priority if (acc_top == '0 || acc_top == '1) begin
      sm_sat = acc_hi[SM_W-1:0];
    end else if (acc_hi[HI_W-1]) begin
      sm_sat = $signed({1'b1, {(SM_W-1){1'b0}}});
    end else begin
      sm_sat = $signed({1'b0, {(SM_W-1){1'b1}}});
    end
  end

  // Minimum test wins over maximum
  always_comb begin
    priority if (acc < lo_x) begin
      cmd = cfg.servo_min;
    end else if (acc > hi_x) begin
      cmd = cfg.servo_max;
    end else begin
      cmd = acc[FRAC+pdsfd_pkg::CMD_W-1:FRAC];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (put) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (put) begin
      servo_command <= cmd;
    end
  end

  `PDSFD_ASSERT_NOW(a_dterm_bound, $past(ctrl.acc_op == pdsfd_pkg::ACC_CLAMP), acc <= $past(lim_x) && acc >= -$past(lim_x), "derivative term escaped its limit")
  `PDSFD_ASSERT_NOW(a_out_from_load, $rose(out_valid), $past(ctrl.load_out), "result word appeared outside the load step")
  `PDSFD_ASSERT_NEXT(a_held_word, ctrl.load_out && out_valid && out_stall, $stable(servo_command), "waiting result word overwritten")

endmodule

[sv/pd_steering_filtered_derivative_core.sv]
// Top level: configuration registers, sequencer and datapath of the PD steering controller.
// Flow: an accepted line_center word runs the 9-step microprogram on the shared multiplier;
//   out_valid rises after the load step. A new word is taken only at the wait step, and
//   the last step waits while a previous result word is still stalled.
// Reset (rst, synchronous): step counter to the wait step, filter state and previous error
//   to zero, configuration registers to their defaults, out_valid low.
module pd_steering_filtered_derivative_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [pdsfd_pkg::POS_W-1:0]     line_center,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [pdsfd_pkg::CMD_W-1:0]     servo_command,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pdsfd_pkg::IDX_W-1:0]     cfg_index,
  input  logic [pdsfd_pkg::WIDE_W-1:0]    cfg_data
);

  pdsfd_pkg::cfg_t  cfg;
  pdsfd_pkg::ctrl_t ctrl;
  pdsfd_pkg::stat_t stat;

  assign cfg_ready = 1'b1;
  assign in_stall  = !ctrl.take_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.camera_center <= pdsfd_pkg::CAMERA_CENTER_RST;
      cfg.prop_gain     <= pdsfd_pkg::PROP_GAIN_RST;
      cfg.deriv_gain    <= pdsfd_pkg::DERIV_GAIN_RST;
      cfg.deriv_limit   <= pdsfd_pkg::DERIV_LIMIT_RST;
      cfg.servo_center  <= pdsfd_pkg::SERVO_CENTER_RST;
      cfg.servo_min     <= pdsfd_pkg::SERVO_MIN_RST;
      cfg.servo_max     <= pdsfd_pkg::SERVO_MAX_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (pdsfd_pkg::reg_idx_t'(cfg_index))
        pdsfd_pkg::REG_CAMERA_CENTER: cfg.camera_center <= cfg_data[pdsfd_pkg::POS_W-1:0];
        pdsfd_pkg::REG_PROP_GAIN:     cfg.prop_gain     <= cfg_data[pdsfd_pkg::GAIN_W-1:0];
        pdsfd_pkg::REG_DERIV_GAIN:    cfg.deriv_gain    <= cfg_data[pdsfd_pkg::GAIN_W-1:0];
        pdsfd_pkg::REG_DERIV_LIMIT:   cfg.deriv_limit   <= cfg_data;
        pdsfd_pkg::REG_SERVO_CENTER:  cfg.servo_center  <= cfg_data;
        pdsfd_pkg::REG_SERVO_MIN:     cfg.servo_min     <= cfg_data;
        pdsfd_pkg::REG_SERVO_MAX:     cfg.servo_max     <= cfg_data;
        default: ;  // unused index, write dropped
      endcase
    end
  end

  pdsfd_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  pdsfd_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (ctrl),
    .cfg           (cfg),
    .in_valid      (in_valid),
    .line_center   (line_center),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .servo_command (servo_command),
    .stat          (stat)
  );

endmodule
